@@ design/wls_pkg.sv @@
`default_nettype none

package wls_pkg;

    localparam int unsigned WINDOW_DEPTH_DEFAULT = 64;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned SUM_W    = 64;

    // 0.95 taken as 19/20; rank tracked incrementally as quotient and remainder
    localparam int unsigned RANK_REM_W = 5;
    localparam logic [RANK_REM_W:0] RANK_NUM = 6'd19;
    localparam logic [RANK_REM_W:0] RANK_DEN = 6'd20;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SUM_W-1:0]    sum_t;

    typedef struct packed {
        logic start;
        logic remove;
    } sort_cmd_t;

endpackage

`default_nettype wire

@@ design/wls_if.sv @@
`default_nettype none

interface wls_sample_if;
    logic              valid;
    logic              ready;
    wls_pkg::sample_t  duration;

    modport source (output valid, output duration, input ready);
    modport sink   (input valid, input duration, output ready);
endinterface

interface wls_result_if;
    logic              valid;
    logic              ready;
    wls_pkg::sample_t  sample_count;
    wls_pkg::sample_t  last_sample;
    wls_pkg::sample_t  min_sample;
    wls_pkg::sample_t  max_sample;
    wls_pkg::sample_t  mean_sample;
    wls_pkg::sample_t  p95_sample;

    modport source (output valid, output sample_count, output last_sample,
                    output min_sample, output max_sample, output mean_sample,
                    output p95_sample, input ready);
    modport sink   (input valid, input sample_count, input last_sample,
                    input min_sample, input max_sample, input mean_sample,
                    input p95_sample, output ready);
endinterface

`default_nettype wire

@@ design/windowed_latency_stats_unit.sv @@
`default_nettype none

// Latency statistics over a sample stream. Each request carries one duration in
// microseconds and yields one result: saturating count, the sample itself, min and
// max since reset, floored mean (sum / count, saturated to 32 bits) and the 95th
// percentile of the last WINDOW_DEPTH samples. One request is in flight at a time;
// samples.ready is high only while idle, and the next request may be taken while
// the previous result still sits in the output register. For each request the
// sorted copy of the window is rebuilt in one merge pass over the samples already
// in the window (up to WINDOW_DEPTH), dropping the evicted sample and inserting the
// new one, while a 64-step restoring divider works out the mean alongside.
// No clearing pass is needed after reset.

module windowed_latency_stats_unit #(
    parameter int unsigned WINDOW_DEPTH = wls_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    wls_sample_if.sink    samples,
    wls_result_if.source  results
);

    import wls_pkg::*;

    localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RING = 3'b010,
        ST_WAIT = 3'b100
    } top_state_t;

    top_state_t             state_reg, state_next;
    sample_t                dur_reg, dur_next;
    sample_t                count_reg, count_next;
    sum_t                   sum_reg, sum_next;
    sample_t                min_reg, min_next;
    sample_t                max_reg, max_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [AW-1:0]          rank_q_reg, rank_q_next;
    logic [RANK_REM_W-1:0]  rank_r_reg, rank_r_next;
    logic                   out_valid_reg, out_valid_next;
    sample_t                o_count_reg, o_count_next;
    sample_t                o_last_reg, o_last_next;
    sample_t                o_min_reg, o_min_next;
    sample_t                o_max_reg, o_max_next;
    sample_t                o_mean_reg, o_mean_next;
    sample_t                o_p95_reg, o_p95_next;

    logic                   accept;
    logic                   window_full;
    logic [SUM_W:0]         sum_wide;
    logic [RANK_REM_W:0]    rank_rsum;
    logic                   ring_we;
    sample_t                ring_old;
    sort_cmd_t              sort_cmd;
    logic                   sort_done;
    sample_t                sort_p95;
    logic                   div_start;
    logic                   div_done;
    sample_t                div_quot;

    assign accept      = samples.valid && (state_reg == ST_IDLE);
    assign window_full = (fill_reg == CW'(WINDOW_DEPTH));
    assign sum_wide    = {1'b0, sum_reg} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, samples.duration};
    assign rank_rsum   = {1'b0, rank_r_reg} + RANK_NUM;

    // ring written and sort/divide launched in the cycle after acceptance,
    // once the evicted entry has come out of the ring read port
    assign ring_we         = (state_reg == ST_RING);
    assign sort_cmd.start  = (state_reg == ST_RING);
    assign sort_cmd.remove = window_full;
    assign div_start       = (state_reg == ST_RING);

    always_comb
    begin
        state_next     = state_reg;
        dur_next       = dur_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        rank_q_next    = rank_q_reg;
        rank_r_next    = rank_r_reg;
        out_valid_next = out_valid_reg;
        o_count_next   = o_count_reg;
        o_last_next    = o_last_reg;
        o_min_next     = o_min_reg;
        o_max_next     = o_max_reg;
        o_mean_next    = o_mean_reg;
        o_p95_next     = o_p95_reg;

        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dur_next = samples.duration;
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    // saturating 64-bit sum
                    sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                    if (samples.duration < min_reg)
                    begin
                        min_next = samples.duration;
                    end
                    if (samples.duration > max_reg)
                    begin
                        max_next = samples.duration;
                    end
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                pos_next = (pos_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                // rank = floor(19*n/20), stepped as n grows by one
                if (!window_full)
                begin
                    fill_next = fill_reg + 1'b1;
                    if (rank_rsum >= RANK_DEN)
                    begin
                        rank_q_next = rank_q_reg + 1'b1;
                        rank_r_next = RANK_REM_W'(rank_rsum - RANK_DEN);
                    end
                    else
                    begin
                        rank_r_next = rank_rsum[RANK_REM_W-1:0];
                    end
                end
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sort_done && div_done && (!out_valid_reg || results.ready))
                begin
                    out_valid_next = 1'b1;
                    o_count_next   = count_reg;
                    o_last_next    = dur_reg;
                    o_min_next     = min_reg;
                    o_max_next     = max_reg;
                    o_mean_next    = div_quot;
                    o_p95_next     = sort_p95;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            rank_q_reg    <= '0;
            rank_r_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            rank_q_reg    <= rank_q_next;
            rank_r_reg    <= rank_r_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_reg     <= dur_next;
        o_count_reg <= o_count_next;
        o_last_reg  <= o_last_next;
        o_min_reg   <= o_min_next;
        o_max_reg   <= o_max_next;
        o_mean_reg  <= o_mean_next;
        o_p95_reg   <= o_p95_next;
    end

    // sample ring; read port always on the write pointer to fetch the evicted entry
    wls_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (pos_reg),
        .wr_data (dur_reg),
        .rd_addr (pos_reg),
        .rd_data (ring_old)
    );

    // sorted window; fill is the old count, rank the new one from rank stepping in the same cycle
    wls_sort #(
        .DEPTH (WINDOW_DEPTH)
    ) u_sort (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (sort_cmd),
        .fill    (fill_reg),
        .rank    (rank_q_next),
        .old_val (ring_old),
        .new_val (dur_reg),
        .done    (sort_done),
        .p95     (sort_p95)
    );

    wls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   (count_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign samples.ready        = (state_reg == ST_IDLE);
    assign results.valid        = out_valid_reg;
    assign results.sample_count = o_count_reg;
    assign results.last_sample  = o_last_reg;
    assign results.min_sample   = o_min_reg;
    assign results.max_sample   = o_max_reg;
    assign results.mean_sample  = o_mean_reg;
    assign results.p95_sample   = o_p95_reg;

endmodule

`default_nettype wire

@@ design/wls_ram.sv @@
`default_nettype none

module wls_ram #(
    parameter  int unsigned WIDTH = 32,
    parameter  int unsigned DEPTH = 64,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ design/wls_div.sv @@
`default_nettype none

module wls_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire wls_pkg::sum_t    num,
    input  wire wls_pkg::sample_t den,
    output logic                  done,
    output wls_pkg::sample_t      quot
);

    import wls_pkg::*;

    localparam int unsigned STEPS  = SUM_W;
    localparam int unsigned STEP_W = $clog2(STEPS + 1);

    // restoring divide, one quotient bit a cycle; quotient shifts in behind numerator
    sum_t                acc_reg, acc_next;
    sample_t             rem_reg, rem_next;
    sample_t             den_reg, den_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [SAMPLE_W:0]   trial;
    logic [SAMPLE_W:0]   diff;
    logic                qbit;

    always_comb
    begin
        trial     = {rem_reg, acc_reg[SUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        qbit      = (trial >= {1'b0, den_reg});
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            acc_next  = num;
            rem_next  = '0;
            den_next  = den;
            step_next = STEP_W'(STEPS);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            acc_next  = {acc_reg[SUM_W-2:0], qbit};
            rem_next  = qbit ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    // saturate when the quotient runs past 32 bits
    assign quot = (|acc_reg[SUM_W-1:SAMPLE_W]) ? '1 : acc_reg[SAMPLE_W-1:0];

endmodule

`default_nettype wire

@@ design/wls_sort.sv @@
`default_nettype none

module wls_sort #(
    parameter  int unsigned DEPTH = wls_pkg::WINDOW_DEPTH_DEFAULT,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wls_pkg::sort_cmd_t cmd,
    input  wire logic [CW-1:0]      fill,
    input  wire logic [AW-1:0]      rank,
    input  wire wls_pkg::sample_t   old_val,
    input  wire wls_pkg::sample_t   new_val,
    output logic                    done,
    output wls_pkg::sample_t        p95
);

    import wls_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_MERGE = 5'b00100,
        S_PICK  = 5'b01000,
        S_PICKW = 5'b10000
    } sort_state_t;

    sort_state_t     state_reg, state_next;
    logic            bank_reg, bank_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic [CW-1:0]   wr_idx_reg, wr_idx_next;
    logic            rem_pend_reg, rem_pend_next;
    logic            ins_pend_reg, ins_pend_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [AW-1:0]   rank_reg, rank_next;
    sample_t         old_reg, old_next;
    sample_t         new_reg, new_next;
    sample_t         p95_reg, p95_next;

    logic            wr_en;
    sample_t         wr_data;
    logic [AW-1:0]   rd_addr;
    sample_t         rd_data0;
    sample_t         rd_data1;
    sample_t         cur;
    sample_t         fresh;

    // sorted window ping-pongs: read bank bank_reg, write the other
    assign cur     = bank_reg ? rd_data1 : rd_data0;
    assign fresh   = bank_reg ? rd_data0 : rd_data1;
    assign rd_addr = (state_reg == S_PICK) ? rank_reg : rd_idx_reg[AW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        rem_pend_next = rem_pend_reg;
        ins_pend_next = ins_pend_reg;
        done_next     = done_reg;
        fill_next     = fill_reg;
        rank_next     = rank_reg;
        old_next      = old_reg;
        new_next      = new_reg;
        p95_next      = p95_reg;
        wr_en         = 1'b0;
        wr_data       = cur;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    rd_idx_next   = '0;
                    wr_idx_next   = '0;
                    rem_pend_next = cmd.remove;
                    ins_pend_next = 1'b1;
                    done_next     = 1'b0;
                    fill_next     = fill;
                    rank_next     = rank;
                    old_next      = old_val;
                    new_next      = new_val;
                    state_next    = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (rd_idx_reg == fill_reg)
                begin
                    // old list used up; new sample goes last if still pending
                    if (ins_pend_reg)
                    begin
                        wr_en         = 1'b1;
                        wr_data       = new_reg;
                        ins_pend_next = 1'b0;
                        wr_idx_next   = wr_idx_reg + 1'b1;
                    end
                    state_next = S_PICK;
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                priority if (rem_pend_reg && (cur == old_reg))
                begin
                    // drop one copy of the evicted sample
                    rem_pend_next = 1'b0;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    state_next    = S_ISSUE;
                end
                else if (ins_pend_reg && (new_reg <= cur))
                begin
                    // read address held, so cur stays for the next cycle
                    wr_en         = 1'b1;
                    wr_data       = new_reg;
                    ins_pend_next = 1'b0;
                    wr_idx_next   = wr_idx_reg + 1'b1;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_data     = cur;
                    wr_idx_next = wr_idx_reg + 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    state_next  = S_ISSUE;
                end
            end
            S_PICK:
            begin
                state_next = S_PICKW;
            end
            S_PICKW:
            begin
                p95_next   = fresh;
                done_next  = 1'b1;
                bank_next  = ~bank_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bank_reg     <= 1'b0;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            rem_pend_reg <= 1'b0;
            ins_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            rem_pend_reg <= rem_pend_next;
            ins_pend_reg <= ins_pend_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg <= fill_next;
        rank_reg <= rank_next;
        old_reg  <= old_next;
        new_reg  <= new_next;
        p95_reg  <= p95_next;
    end

    wls_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (wr_en & bank_reg),
        .wr_addr (wr_idx_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data0)
    );

    wls_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (wr_en & ~bank_reg),
        .wr_addr (wr_idx_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data1)
    );

    assign done = done_reg;
    assign p95  = p95_reg;

endmodule

`default_nettype wire
